FILE: rtl/mutex_with_fifo_wait_queue_top_defines.svh
// assertion macros for the mutex with fifo wait queue
`ifndef MUTEX_WITH_FIFO_WAIT_QUEUE_TOP_DEFINES_SVH
`define MUTEX_WITH_FIFO_WAIT_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define MWQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mutex queue check failed");

// next-cycle implication, clocked on clk_i, off during reset
`define MWQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mutex queue check failed");

`endif

FILE: rtl/mwq_pkg.sv
// shared types and constants of the mutex with fifo wait queue
package mwq_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned IdBitsDef     = 8;
  localparam int unsigned ReqTypeW      = 2;
  localparam int unsigned FieldIdW      = 8;
  localparam int unsigned WaitCntW      = 5;

  typedef enum logic [ReqTypeW-1:0] {
    REQ_LOCK    = 2'd0,
    REQ_TRYLOCK = 2'd1,
    REQ_UNLOCK  = 2'd2
  } req_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [ReqTypeW-1:0] req_type;
    logic [FieldIdW-1:0] requester_id;
  } req_t;

  typedef struct packed {
    logic                granted;
    logic                queued;
    logic                overflow;
    logic                handed_over;
    logic                unlock_ignored;
    logic                is_held;
    logic [FieldIdW-1:0] owner_id;
    logic [WaitCntW-1:0] waiter_count;
  } res_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

FILE: rtl/mwq_ctrl.sv
// controller state machine of the mutex with fifo wait queue
module mwq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mwq_pkg::cmd_t cmd_o
);

  mwq_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mwq_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    in_ready_o    = 1'b0;
    unique case (state_q)
      mwq_pkg::ST_IDLE: begin
        // no word taken while reset is held
        in_ready_o = rst_ni;
        if (in_valid_i && rst_ni) begin
          cmd_o.capture = 1'b1;
          state_d       = mwq_pkg::ST_EXEC;
        end
      end
      mwq_pkg::ST_EXEC: begin
        // result slot free or being drained this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.execute = 1'b1;
          state_d       = mwq_pkg::ST_IDLE;
        end
      end
      default: state_d = mwq_pkg::ST_IDLE;
    endcase
    out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.execute;
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/mwq_dpath.sv
// datapath of the mutex: owner state, waiter memory and pointers, result word
module mwq_dpath #(
  parameter int unsigned QUEUE_DEPTH = mwq_pkg::QueueDepthDef,
  parameter int unsigned ID_BITS     = mwq_pkg::IdBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mwq_pkg::cmd_t cmd_i,
  input  mwq_pkg::req_t req_i,
  output mwq_pkg::res_t res_o
);

  localparam int unsigned IdW  = (ID_BITS < mwq_pkg::FieldIdW) ? ID_BITS : mwq_pkg::FieldIdW;
  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [mwq_pkg::ReqTypeW-1:0] kind_q;
  logic [IdW-1:0]               id_q;

  logic            held_q, held_d;
  logic [IdW-1:0]  owner_q, owner_d;
  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [IdW-1:0]  mem_q [QUEUE_DEPTH];
  logic [IdW-1:0]  head_data_q;
  logic            wr_en;

  mwq_pkg::res_t res_q, res_d;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  // request capture, no reset on payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= req_i.req_type;
      id_q   <= req_i.requester_id[IdW-1:0];
    end
  end

  // waiter memory, head entry read every cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[tail_q] <= id_q;
    end
    head_data_q <= mem_q[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      owner_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
    end else if (cmd_i.execute) begin
      held_q  <= held_d;
      owner_q <= owner_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    held_d  = held_q;
    owner_d = owner_q;
    head_d  = head_q;
    tail_d  = tail_q;
    cnt_d   = cnt_q;
    wr_en   = 1'b0;
    res_d   = '0;
    unique case (kind_q)
      mwq_pkg::REQ_LOCK, mwq_pkg::REQ_TRYLOCK: begin
        if (!held_q) begin
          held_d        = 1'b1;
          owner_d       = id_q;
          res_d.granted = 1'b1;
        end else if (kind_q == mwq_pkg::REQ_LOCK) begin
          if (cnt_q == CntW'(QUEUE_DEPTH)) begin
            res_d.overflow = 1'b1;
          end else begin
            wr_en        = cmd_i.execute;
            tail_d       = next_ptr(tail_q);
            cnt_d        = cnt_q + CntW'(1);
            res_d.queued = 1'b1;
          end
        end
      end
      mwq_pkg::REQ_UNLOCK: begin
        if (held_q && owner_q == id_q) begin
          if (cnt_q == '0) begin
            held_d  = 1'b0;
            owner_d = '0;
          end else begin
            owner_d           = head_data_q;
            head_d            = next_ptr(head_q);
            cnt_d             = cnt_q - CntW'(1);
            res_d.handed_over = 1'b1;
          end
        end else begin
          res_d.unlock_ignored = 1'b1;
        end
      end
      default: ;
    endcase
    res_d.is_held      = held_d;
    res_d.owner_id     = held_d ? mwq_pkg::FieldIdW'(owner_d) : '0;
    res_d.waiter_count = mwq_pkg::WaitCntW'(cnt_d);
  end

  assign res_o = res_q;

endmodule

FILE: rtl/mutex_with_fifo_wait_queue_top.sv
// top level of the hardware mutex with a fifo queue of waiters
// One mutex shared by numbered processes. Each input word is a request (lock,
// trylock or unlock) with the requester id; each request gives exactly one
// result word with the outcome flags and the mutex state after the request.
// A request is captured at its accepting edge and then, in a separate update
// step, changes the owner and queue and loads the result register; the update
// follows the capture because the waiter memory is read through a registered
// port at the queue head. The result is valid once the update has loaded it.
// A new request is accepted only after the update of the previous request.
// The
// result sits in an output register, so the next request is taken while the
// previous result still waits; a request stalls in its update cycle only when
// that register still holds an untaken result. Waiter ids live in a
// QUEUE_DEPTH-entry memory with no reset; the head, tail and count registers
// reset to empty, so no clearing pass is needed and the block is ready right
// after reset. Only the low ID_BITS bits of requester_id take part (at most 8).
// A lock on a full queue is dropped with overflow set; an unlock from a
// non-owner or on a free mutex sets unlock_ignored; request type 3 changes
// nothing and reports the current state.
module mutex_with_fifo_wait_queue_top #(
  parameter int unsigned QUEUE_DEPTH = mwq_pkg::QueueDepthDef,
  parameter int unsigned ID_BITS     = mwq_pkg::IdBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // request word in
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mwq_pkg::req_t in_data_i,
  // result word out
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mwq_pkg::res_t out_data_o
);

  // capture and update strobes from the controller
  mwq_pkg::cmd_t cmd;

  mwq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // owner, queue pointers, waiter memory and result register
  mwq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (in_data_i),
    .res_o  (out_data_o)
  );

endmodule

FILE: rtl/mwq_checker.sv
// port-level checks of the mutex with fifo wait queue, bound to the top level
`include "mutex_with_fifo_wait_queue_top_defines.svh"

module mwq_assert_checker #(
  parameter int unsigned QUEUE_DEPTH = mwq_pkg::QueueDepthDef
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input mwq_pkg::res_t out_data_i
);

  // outcome flags of the result word
  logic [4:0] out_flags;

  assign out_flags = {out_data_i.granted, out_data_i.queued, out_data_i.overflow,
                      out_data_i.handed_over, out_data_i.unlock_ignored};

  `MWQ_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `MWQ_ASSERT_IMPL(a_flags_onehot, out_valid_i, $onehot0(out_flags))
  `MWQ_ASSERT_IMPL(a_free_owner_zero, out_valid_i && !out_data_i.is_held, out_data_i.owner_id == '0)
  `MWQ_ASSERT_IMPL(a_count_bound, out_valid_i, 32'(out_data_i.waiter_count) <= QUEUE_DEPTH)

endmodule

bind mutex_with_fifo_wait_queue_top mwq_assert_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_mwq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
